FILE: rtl/core/ansi_text_terminal_defines.svh
// Assertion macros for the terminal checker.
`ifndef ANSI_TEXT_TERMINAL_DEFINES_SVH
`define ANSI_TEXT_TERMINAL_DEFINES_SVH
`define ATT_ASSERT_IMPL(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ATT_ASSERT_RST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: rtl/core/att_pkg.sv
// Shared types, constants and helpers of the text terminal.
package att_pkg;
   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF = 25;
   localparam int MAX_PARAMS_DEF = 8;
   localparam logic [30:0] PARAM_SAT = 31'd2147483647;
   localparam logic [30:0] PARAM_LIM = 31'd214748364;
   localparam logic [7:0] ESC_CODE = 8'h1b;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_FILL = 2'd1;
   localparam logic [1:0] KIND_SCROLL = 2'd2;
   localparam logic [1:0] KIND_CURSOR = 2'd3;

   localparam logic CSR_FORE = 1'b0;
   localparam logic CSR_BACK = 1'b1;

   typedef enum logic [1:0] {MODE_NORMAL, MODE_ESC, MODE_CSI, MODE_SPARE} mode_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PARSE, ST_SGR, ST_EMIT, ST_WAIT
   } state_type;

   typedef struct packed {
      logic       parse;
      logic       sgr_step;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic       sgr_busy;
      logic [1:0] count;
      logic       out_busy;
   } sts_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [10:0] s;
      logic [10:0] e;
      logic [7:0]  g;
      logic [7:0]  a;
      logic [10:0] cp;
   } res_type;

   function automatic logic [2:0] ansi_to_vga(input logic [2:0] c);
      logic [2:0] r;
      r = {c[0], c[1], c[2]};
      return r;
   endfunction
endpackage

FILE: rtl/core/att_ctrl.sv
// Sequencer of the text terminal: parse, SGR walk, result emission.
module att_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  att_pkg::sts_type sts,
   output att_pkg::cmd_type cmd
);
   import att_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_PARSE;
         ST_PARSE: state_in = ST_SGR;
         ST_SGR: if (!sts.sgr_busy) state_in = ST_EMIT;
         ST_EMIT: if (sts.count == 2'd0) state_in = ST_WAIT;
         ST_WAIT: if (!sts.out_busy) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_PARSE: cmd.parse = 1'b1;
         ST_SGR: cmd.sgr_step = sts.sgr_busy;
         ST_EMIT: cmd.emit = 1'b1;
         default: ;
      endcase
   end
endmodule

FILE: rtl/core/att_dp.sv
// Datapath of the text terminal: parser state, cursor, colors and results.
module att_dp #(
   parameter int COLUMNS = att_pkg::COLUMNS_DEF,
   parameter int ROWS = att_pkg::ROWS_DEF,
   parameter int MAX_PARAMS = att_pkg::MAX_PARAMS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_fire,
   input  logic [7:0]       req_char,
   input  logic             csr_fire,
   input  logic             csr_index,
   input  logic [3:0]       csr_data,
   input  att_pkg::cmd_type cmd,
   output att_pkg::sts_type sts,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output att_pkg::res_type rsp_res,
   output logic             rsp_last
);
   import att_pkg::*;
   localparam int RW = $clog2(ROWS);
   localparam int CW = $clog2(COLUMNS);
   localparam int PW = $clog2(MAX_PARAMS);
   localparam int NW = $clog2(MAX_PARAMS + 1);
   localparam logic [10:0] CELLS = 11'(ROWS * COLUMNS);
   localparam logic [10:0] COLS11 = 11'(COLUMNS);

   logic [3:0] dfg_ff, dbg_ff;
   logic [7:0] ch_ff;
   mode_type mode_ff;
   logic [30:0] par_ff [MAX_PARAMS];
   logic [NW-1:0] pcnt_ff;
   logic priv_ff, drop_ff, bold_ff, hid_ff;
   logic [RW-1:0] row_ff, srow_ff;
   logic [CW-1:0] col_ff, scol_ff;
   logic [3:0] fg_ff, bg_ff;
   logic sgr_ff;
   logic [NW-1:0] sidx_ff;
   res_type q_ff [3];
   logic [1:0] qn_ff, qi_ff;
   res_type o_ff;
   logic ov_ff, ol_ff;

   // parse step scratch
   res_type r [3];
   logic [1:0] n;
   logic [RW:0] nr;
   logic [CW:0] nc;
   logic [31:0] p0, p1, mval;
   logic [31:0] d32;
   logic dig;
   logic [PW-1:0] pidx;
   logic [10:0] here, rstart;
   logic [7:0] at;

   function automatic res_type mk(input logic [1:0] k, input logic [10:0] s,
      input logic [10:0] e, input logic [7:0] g, input logic [7:0] a,
      input logic [10:0] cp);
      res_type x;
      x.kind = k; x.s = s; x.e = e; x.g = g; x.a = a; x.cp = cp;
      return x;
   endfunction

   assign dig = ch_ff >= "0" && ch_ff <= "9";
   assign pidx = PW'((pcnt_ff == '0 ? NW'(0) : pcnt_ff - NW'(1)));
   assign at = {bg_ff, fg_ff};
   assign rstart = 11'({1'b0, row_ff} * COLUMNS);
   assign here = rstart + 11'(col_ff);
   assign d32 = 32'(ch_ff - "0");
   assign p0 = (pcnt_ff >= NW'(1) && par_ff[0] != '0) ? {1'b0, par_ff[0]} : 32'd1;
   assign p1 = (pcnt_ff >= NW'(2) && par_ff[1] != '0) ? {1'b0, par_ff[1]} : 32'd1;
   assign mval = pcnt_ff >= NW'(1) ? {1'b0, par_ff[0]} : 32'd0;

   function automatic logic [10:0] cpos(input logic h, input logic [RW:0] rr,
      input logic [CW:0] cc);
      return h ? CELLS : 11'(11'(rr) * COLS11 + 11'(cc));
   endfunction

   always_comb begin
      r[0] = '0; r[1] = '0; r[2] = '0;
      n = 2'd0;
      nr = {1'b0, row_ff};
      nc = {1'b0, col_ff};
      if (mode_ff == MODE_CSI && (!drop_ff || !(ch_ff == ";" || ch_ff == "?" || dig))
          && (drop_ff || !(ch_ff == ";" || ch_ff == "?" || dig))) begin
         if (priv_ff) begin
            if (par_ff[0] == 31'd25 && (ch_ff == "h" || ch_ff == "l")) begin
               r[0] = mk(KIND_CURSOR, '0, '0, '0, '0, cpos(ch_ff == "l", nr, nc));
               n = 2'd1;
            end
         end else begin
            priority case (ch_ff)
               "H", "f": begin
                  nr = (p0 - 32'd1 >= 32'(ROWS)) ? (RW+1)'(ROWS - 1) : (RW+1)'(p0 - 32'd1);
                  nc = (p1 - 32'd1 >= 32'(COLUMNS)) ? (CW+1)'(COLUMNS - 1)
                     : (CW+1)'(p1 - 32'd1);
                  r[0] = mk(KIND_CURSOR, '0, '0, '0, '0, cpos(hid_ff, nr, nc)); n = 2'd1;
               end
               "A": begin
                  nr = (32'(row_ff) >= p0) ? (RW+1)'(32'(row_ff) - p0) : '0;
                  r[0] = mk(KIND_CURSOR, '0, '0, '0, '0, cpos(hid_ff, nr, nc)); n = 2'd1;
               end
               "B": begin
                  nr = (p0 >= 32'(ROWS) - 32'(row_ff)) ? (RW+1)'(ROWS - 1)
                     : (RW+1)'(32'(row_ff) + p0);
                  r[0] = mk(KIND_CURSOR, '0, '0, '0, '0, cpos(hid_ff, nr, nc)); n = 2'd1;
               end
               "C": begin
                  nc = (p0 >= 32'(COLUMNS) - 32'(col_ff)) ? (CW+1)'(COLUMNS - 1)
                     : (CW+1)'(32'(col_ff) + p0);
                  r[0] = mk(KIND_CURSOR, '0, '0, '0, '0, cpos(hid_ff, nr, nc)); n = 2'd1;
               end
               "D": begin
                  nc = (32'(col_ff) >= p0) ? (CW+1)'(32'(col_ff) - p0) : '0;
                  r[0] = mk(KIND_CURSOR, '0, '0, '0, '0, cpos(hid_ff, nr, nc)); n = 2'd1;
               end
               "J": begin
                  if (mval == 32'd2) begin
                     r[0] = mk(KIND_FILL, '0, CELLS - 11'd1, 8'h20, at, '0);
                     nr = '0; nc = '0;
                     r[1] = mk(KIND_CURSOR, '0, '0, '0, '0, cpos(hid_ff, nr, nc));
                     n = 2'd2;
                  end else if (mval == 32'd0) begin
                     r[0] = mk(KIND_FILL, here, CELLS - 11'd1, 8'h20, at, '0); n = 2'd1;
                  end
               end
               "K": begin
                  if (mval == 32'd0) begin
                     r[0] = mk(KIND_FILL, here, rstart + COLS11 - 11'd1, 8'h20, at, '0);
                     n = 2'd1;
                  end else if (mval == 32'd1) begin
                     r[0] = mk(KIND_FILL, rstart, here, 8'h20, at, '0); n = 2'd1;
                  end else if (mval == 32'd2) begin
                     r[0] = mk(KIND_FILL, rstart, rstart + COLS11 - 11'd1, 8'h20, at, '0);
                     n = 2'd1;
                  end
               end
               "u": begin
                  nr = {1'b0, srow_ff}; nc = {1'b0, scol_ff};
                  r[0] = mk(KIND_CURSOR, '0, '0, '0, '0, cpos(hid_ff, nr, nc)); n = 2'd1;
               end
               default: ;
            endcase
         end
      end else if (mode_ff == MODE_NORMAL || mode_ff == MODE_SPARE) begin
         if (ch_ff == ESC_CODE) begin
         end else if (ch_ff == 8'h0a || ch_ff == 8'h0d) begin
            nc = '0;
            if (ch_ff == 8'h0a) begin
               if (32'(row_ff) + 32'd1 >= 32'(ROWS)) begin
                  r[0] = mk(KIND_SCROLL, CELLS - COLS11, CELLS - 11'd1, 8'h20, at, '0);
                  n = 2'd1;
               end else nr = nr + (RW+1)'(1);
            end
            r[n] = mk(KIND_CURSOR, '0, '0, '0, '0, cpos(hid_ff, nr, nc));
            n = n + 2'd1;
         end else if (ch_ff == 8'h08) begin
            if (col_ff != '0) begin
               nc = nc - (CW+1)'(1);
               r[0] = mk(KIND_WRITE, here - 11'd1, here - 11'd1, 8'h20, at, '0); n = 2'd1;
            end
            r[n] = mk(KIND_CURSOR, '0, '0, '0, '0, cpos(hid_ff, nr, nc));
            n = n + 2'd1;
         end else begin
            r[0] = mk(KIND_WRITE, here, here, ch_ff, at, '0); n = 2'd1;
            nc = nc + (CW+1)'(1);
            if (32'(nc) >= 32'(COLUMNS)) begin
               nc = '0;
               if (32'(row_ff) + 32'd1 >= 32'(ROWS)) begin
                  r[1] = mk(KIND_SCROLL, CELLS - COLS11, CELLS - 11'd1, 8'h20, at, '0);
                  n = 2'd2;
               end else nr = nr + (RW+1)'(1);
            end
            r[n] = mk(KIND_CURSOR, '0, '0, '0, '0, cpos(hid_ff, nr, nc));
            n = n + 2'd1;
         end
      end
   end

   logic dispatch;
   assign dispatch = mode_ff == MODE_CSI
      && !(ch_ff == ";" || ch_ff == "?" || dig) && !(!drop_ff && 1'b0);

   // SGR walk: one parameter per cycle
   logic [30:0] sv;
   logic [3:0] fg_n, bg_n;
   logic bold_n;
   assign sv = par_ff[PW'(sidx_ff)];
   always_comb begin
      fg_n = fg_ff; bg_n = bg_ff; bold_n = bold_ff;
      if (sv == 31'd0) begin
         fg_n = dfg_ff; bg_n = dbg_ff; bold_n = 1'b0;
      end else if (sv == 31'd1) begin
         bold_n = 1'b1; fg_n = {1'b1, fg_ff[2:0]};
      end else if (sv == 31'd22) begin
         bold_n = 1'b0; fg_n = {1'b0, fg_ff[2:0]};
      end else if (sv >= 31'd30 && sv <= 31'd37) begin
         fg_n = {bold_ff, ansi_to_vga(3'(sv - 31'd30))};
      end else if (sv >= 31'd40 && sv <= 31'd47) begin
         bg_n = {1'b0, ansi_to_vga(3'(sv - 31'd40))};
      end else if (sv >= 31'd90 && sv <= 31'd97) begin
         fg_n = {1'b1, ansi_to_vga(3'(sv - 31'd90))}; bold_n = 1'b1;
      end else if (sv >= 31'd100 && sv <= 31'd107) begin
         bg_n = {1'b1, ansi_to_vga(3'(sv - 31'd100))};
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) ch_ff <= req_char;
      if (reset) begin
         dfg_ff <= 4'd10; dbg_ff <= 4'd0;
         mode_ff <= MODE_NORMAL;
         for (int i = 0; i < MAX_PARAMS; i++) par_ff[i] <= '0;
         pcnt_ff <= '0; priv_ff <= 1'b0; drop_ff <= 1'b0; bold_ff <= 1'b0;
         row_ff <= '0; col_ff <= '0; srow_ff <= '0; scol_ff <= '0;
         fg_ff <= 4'd10; bg_ff <= 4'd0; hid_ff <= 1'b0;
         sgr_ff <= 1'b0; sidx_ff <= '0; qn_ff <= '0; qi_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         if (csr_fire) begin
            if (csr_index == CSR_FORE) dfg_ff <= csr_data;
            else dbg_ff <= csr_data;
         end
         if (cmd.parse) begin
            for (int i = 0; i < 3; i++) q_ff[i] <= r[i];
            qn_ff <= n; qi_ff <= '0;
            row_ff <= RW'(nr); col_ff <= CW'(nc);
            unique case (mode_ff)
               MODE_ESC: begin
                  if (ch_ff == "[") begin
                     mode_ff <= MODE_CSI;
                     pcnt_ff <= '0; priv_ff <= 1'b0; drop_ff <= 1'b0;
                     for (int i = 0; i < MAX_PARAMS; i++) par_ff[i] <= '0;
                  end else mode_ff <= (ch_ff == ESC_CODE) ? MODE_ESC : MODE_NORMAL;
               end
               MODE_CSI: begin
                  if (dispatch) begin
                     mode_ff <= MODE_NORMAL; drop_ff <= 1'b0;
                     if (!priv_ff) begin
                        if (ch_ff == "s") begin srow_ff <= row_ff; scol_ff <= col_ff; end
                        if (ch_ff == "m") begin
                           if (pcnt_ff == '0) begin
                              fg_ff <= dfg_ff; bg_ff <= dbg_ff; bold_ff <= 1'b0;
                           end else begin
                              sgr_ff <= 1'b1; sidx_ff <= '0;
                           end
                        end
                     end else if (par_ff[0] == 31'd25 && (ch_ff == "h" || ch_ff == "l"))
                        hid_ff <= ch_ff == "l";
                  end else if (!drop_ff) begin
                     if (ch_ff == "?") priv_ff <= 1'b1;
                     else if (dig) begin
                        if (pcnt_ff == '0) pcnt_ff <= NW'(1);
                        if (par_ff[pidx] > PARAM_LIM
                            || (par_ff[pidx] == PARAM_LIM && d32 > 32'd7))
                           par_ff[pidx] <= PARAM_SAT;
                        else par_ff[pidx] <= 31'(par_ff[pidx] * 31'd10 + 31'(d32));
                     end else begin
                        if (pcnt_ff < NW'(MAX_PARAMS))
                           pcnt_ff <= (pcnt_ff == '0) ? NW'(2) : pcnt_ff + NW'(1);
                        else drop_ff <= 1'b1;
                     end
                  end
               end
               default: mode_ff <= (ch_ff == ESC_CODE) ? MODE_ESC : MODE_NORMAL;
            endcase
         end
         if (cmd.sgr_step) begin
            fg_ff <= fg_n; bg_ff <= bg_n; bold_ff <= bold_n;
            sidx_ff <= sidx_ff + NW'(1);
            if (sidx_ff + NW'(1) >= pcnt_ff) sgr_ff <= 1'b0;
         end
         if (cmd.emit && qn_ff != '0 && (!ov_ff || rsp_tready)) begin
            o_ff <= q_ff[qi_ff];
            ol_ff <= qn_ff == 2'd1;
            ov_ff <= 1'b1;
            qi_ff <= qi_ff + 2'd1;
            qn_ff <= qn_ff - 2'd1;
         end else if (ov_ff && rsp_tready) ov_ff <= 1'b0;
      end
   end

   assign sts.sgr_busy = sgr_ff;
   assign sts.count = qn_ff;
   assign sts.out_busy = ov_ff;
   assign rsp_tvalid = ov_ff;
   assign rsp_res = o_ff;
   assign rsp_last = ol_ff;
endmodule

FILE: rtl/core/ansi_text_terminal.sv
// Top level of the ANSI text terminal front end.
// Channels: req_ carries one character byte per item in tdata[7:0].
// rsp_ carries text-buffer commands; tlast marks the final command of a byte.
// csr_ writes default_foreground (index 0) and default_background (index 1).
// A byte passes the accept state, a parse step, the SGR walk with one step per
// SGR parameter, one emission per command (0 to 3), and a drain wait.
// The per-parameter SGR walk and the single output register set the rate.
// A byte is taken only when the previous byte's commands are all delivered.
// The first command is registered in the emit state, after the parse and SGR states.
// Reset (synchronous, active high) returns to normal mode, cursor at the
// top left, colors at the reset defaults.
// When rsp_tready is low the command register holds and the sequencer waits;
// no command is lost or repeated.
module ansi_text_terminal #(
   parameter int COLUMNS = att_pkg::COLUMNS_DEF,
   parameter int ROWS = att_pkg::ROWS_DEF,
   parameter int MAX_PARAMS = att_pkg::MAX_PARAMS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // char_code
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // command_kind, start_cell, end_cell, glyph,
                                    // attribute, cursor_position, zero fill
   output logic        rsp_tlast,   // last_of_run
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [3:0]  csr_data
);
   import att_pkg::*;
   cmd_type cmd;
   sts_type sts;
   res_type res;

   assign csr_ready = 1'b1;

   att_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .sts, .cmd
   );

   att_dp #(.COLUMNS(COLUMNS), .ROWS(ROWS), .MAX_PARAMS(MAX_PARAMS)) u_dp (
      .clock, .reset,
      .req_fire(req_tvalid && req_tready), .req_char(req_tdata),
      .csr_fire(csr_valid), .csr_index, .csr_data,
      .cmd, .sts, .rsp_tvalid, .rsp_tready, .rsp_res(res), .rsp_last(rsp_tlast)
   );

   assign rsp_tdata = {5'b00000, res.cp, res.a, res.g, res.e, res.s, res.kind};
endmodule

FILE: rtl/core/att_checker.sv
// Port checker for the terminal, bound to the top level.
`include "ansi_text_terminal_defines.svh"
module att_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tlast
);
   `ATT_ASSERT_IMPL(a_hold, clock, reset, rsp_tvalid && !rsp_tready |=> $stable({rsp_tlast, rsp_tdata}), "stalled command changed")
   `ATT_ASSERT_IMPL(a_noaccept_busy, clock, reset, rsp_tvalid |-> !req_tready, "byte taken while commands pending")
   `ATT_ASSERT_IMPL(a_gap, clock, reset, req_tvalid && req_tready |=> !rsp_tvalid, "command too early")
   `ATT_ASSERT_RST(a_rst, clock, reset |=> !rsp_tvalid, "command after reset")
endmodule

bind ansi_text_terminal att_checker u_chk (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
   .rsp_tdata, .rsp_tlast
);
